/* sv/first_fit_block_allocator_assert.svh */
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/ffba_pkg.sv */
package ffba_pkg;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [4:0]  block_slot;
		logic [15:0] size_value;
	} ffba_in_t;

	typedef struct packed {
		logic        granted;
		logic [4:0]  chosen_block;
		logic [15:0] chosen_size;
		logic [15:0] leftover;
	} ffba_out_t;

	typedef struct packed {
		logic        live;
		logic [15:0] req;
	} ffba_tok_t;

	typedef struct packed {
		logic        hit;
		logic        miss;
		logic [15:0] size;
		logic [15:0] left;
	} ffba_evt_t;

endpackage

/* sv/ffba_cell.sv */
module ffba_cell #(
	parameter int SIZE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_en,
	input  logic [15:0]        load_value,
	input  logic               act,
	input  ffba_pkg::ffba_tok_t tok_in,
	output ffba_pkg::ffba_tok_t tok_out,
	output ffba_pkg::ffba_evt_t evt
);
	import ffba_pkg::*;

	localparam int CW = (SIZE_BITS > 16) ? SIZE_BITS : 16;

	logic [SIZE_BITS-1:0] size_q;
	logic                 used_q;
	logic                 live_q;
	logic [15:0]          req_q;
	logic [CW-1:0]        size_w;
	logic [CW-1:0]        req_w;
	logic                 fit;
	logic                 hit;

	assign size_w = CW'(size_q);
	assign req_w  = CW'(tok_in.req);
	assign fit    = size_w >= req_w;
	assign hit    = tok_in.live && act && !used_q && fit;

	always_comb begin
		evt.hit  = hit;
		evt.miss = tok_in.live && !act;
		evt.size = hit ? 16'(size_w) : '0;
		evt.left = hit ? 16'(size_w - req_w) : '0;
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			size_q <= SIZE_BITS'(load_value);
		end
		req_q <= tok_in.req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			live_q <= 1'b0;
		end else begin
			if (load_en) begin
				used_q <= 1'b0;
			end else if (hit) begin
				used_q <= 1'b1;
			end
			live_q <= tok_in.live && act && !hit;
		end
	end

	assign tok_out.live = live_q;
	assign tok_out.req  = req_q;

endmodule

/* sv/first_fit_block_allocator.sv */
// load: no result, and item_stall stays low, so loads can follow one another
// allocation: the request walks one cell a cycle from entry 0; the result names
//   the first unused entry that fits, else no fit at min(block_count, NUM_BLOCKS)
// one item at a time: input stalls until the result is taken
// reset clears block_count and all used flags; block sizes undefined until loaded
module first_fit_block_allocator #(
	parameter int NUM_BLOCKS = 32,
	parameter int SIZE_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  ffba_pkg::ffba_in_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output ffba_pkg::ffba_out_t result,
	input  logic                cfg_we,
	input  logic [5:0]          cfg_data
);
	import ffba_pkg::*;

	logic        acc;
	logic [5:0]  count_q;
	logic        srch_q;
	logic        out_valid_q;
	ffba_out_t   out_q;
	logic        launch_q;
	logic [15:0] launch_req_q;
	logic        done;
	ffba_out_t   res_d;

	ffba_tok_t tok_c [NUM_BLOCKS+1];
	ffba_evt_t evt_c [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] act_c;
	logic [NUM_BLOCKS-1:0] load_c;

	assign item_stall   = srch_q || out_valid_q;
	assign acc          = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign tok_c[0].live = launch_q;
	assign tok_c[0].req  = launch_req_q;

	genvar g;
	generate
		for (g = 0; g < NUM_BLOCKS; g++) begin : g_cell
			assign act_c[g]  = 32'(g) < 32'(count_q);
			assign load_c[g] = acc && (item.cmd == CMD_LOAD) && (32'(item.block_slot) == 32'(g));
			ffba_cell #(
				.SIZE_BITS(SIZE_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.load_en   (load_c[g]),
				.load_value(item.size_value),
				.act       (act_c[g]),
				.tok_in    (tok_c[g]),
				.tok_out   (tok_c[g+1]),
				.evt       (evt_c[g])
			);
		end
	endgenerate

	always_comb begin
		res_d = '0;
		done  = tok_c[NUM_BLOCKS].live;
		for (int k = 0; k < NUM_BLOCKS; k++) begin
			done = done || evt_c[k].hit || evt_c[k].miss;
			if (evt_c[k].hit) begin
				res_d.granted      = 1'b1;
				res_d.chosen_block = res_d.chosen_block | 5'(k);
			end
			res_d.chosen_size = res_d.chosen_size | evt_c[k].size;
			res_d.leftover    = res_d.leftover | evt_c[k].left;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			launch_req_q <= item.size_value;
		end
		if (srch_q && done) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			srch_q      <= 1'b0;
			out_valid_q <= 1'b0;
			launch_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			launch_q <= acc && (item.cmd == CMD_ALLOC);
			if (acc && (item.cmd == CMD_ALLOC)) begin
				srch_q <= 1'b1;
			end else if (srch_q && done) begin
				srch_q <= 1'b0;
			end
			if (srch_q && done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/ffba_checker.sv */
`include "first_fit_block_allocator_assert.svh"

module ffba_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input logic                result_valid,
	input logic                result_stall,
	input ffba_pkg::ffba_out_t result
);
	import ffba_pkg::*;

	`FFBA_ASSERT_NOW(a_nofit_zero, result_valid && !result.granted,
		result.chosen_block == 5'd0 && result.chosen_size == 16'd0 && result.leftover == 16'd0,
		"no-fit result carries nonzero fields")

	`FFBA_ASSERT_NOW(a_left_le_size, result_valid && result.granted,
		result.leftover <= result.chosen_size, "leftover exceeds block size")

	`FFBA_ASSERT_NOW(a_one_at_a_time, result_valid, item_stall,
		"request accepted while a result is pending")

	`FFBA_ASSERT_NXT(a_no_early_result, item_valid && !item_stall, !result_valid,
		"result shown in the cycle after a request")

	`FFBA_ASSERT_NXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(result), "stalled result changed")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import ffba_pkg::*;

	localparam int NUM_ENTRIES = 32;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 235;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_PRINTS = 50;
	localparam ffba_out_t NO_FIT = '0;
	localparam logic [5:0] PHASE_COUNTS [8] = '{
		6'd32, 6'd63, 6'd1, 6'd33, 6'd0, 6'd17, 6'd2, 6'd32
	};

	typedef struct packed {
		bit        is_cfg;
		logic [5:0] count;
		ffba_in_t  req;
		bit        typed;
		ffba_out_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	ffba_in_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	ffba_out_t result;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_data = '0;

	logic [15:0] table_size [NUM_ENTRIES];
	bit table_used [NUM_ENTRIES];
	logic [5:0] table_count;

	ffba_out_t grants_due [$];
	ffba_out_t oldest;
	int error_count = 0;
	int accepted_items = 0;
	int burst_left = 1;
	bit offering = 1'b0;

	dir_row_t directed_rows [22] = '{
		'{1'b1, 6'd0, '{CMD_LOAD, 5'd0, 16'h0000}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd0, 16'h0000}, 1'b1, NO_FIT},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd0, 16'hFFFF}, 1'b1, NO_FIT},
		'{1'b1, 6'd4, '{CMD_LOAD, 5'd0, 16'h0000}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_LOAD, 5'd0, 16'hFFFF}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_LOAD, 5'd1, 16'h0000}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_LOAD, 5'd2, 16'd100}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_LOAD, 5'd3, 16'h8000}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_LOAD, 5'd31, 16'h1234}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd0, 16'h0000}, 1'b1, '{1'b1, 5'd0, 16'hFFFF, 16'hFFFF}},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd0, 16'h0000}, 1'b1, '{1'b1, 5'd1, 16'h0000, 16'h0000}},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd0, 16'hFFFF}, 1'b1, NO_FIT},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd31, 16'd50}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd10, 16'd1}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd0, 16'h0000}, 1'b1, NO_FIT},
		'{1'b0, 6'd0, '{CMD_LOAD, 5'd0, 16'd7}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd0, 16'd7}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd0, 16'd8}, 1'b1, NO_FIT},
		'{1'b1, 6'd1, '{CMD_LOAD, 5'd0, 16'h0000}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_LOAD, 5'd0, 16'hFFFF}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd21, 16'hFFFF}, 1'b0, NO_FIT},
		'{1'b0, 6'd0, '{CMD_ALLOC, 5'd0, 16'h0000}, 1'b1, NO_FIT}
	};

	first_fit_block_allocator #(
		.NUM_BLOCKS(NUM_ENTRIES),
		.SIZE_BITS(16)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic bit first_fit_predict(input ffba_in_t r, output ffba_out_t o);
		int limit;
		o = '0;
		if (r.cmd == CMD_LOAD) begin
			table_size[r.block_slot] = r.size_value;
			table_used[r.block_slot] = 1'b0;
			return 1'b0;
		end
		limit = (table_count > NUM_ENTRIES) ? NUM_ENTRIES : int'(table_count);
		for (int k = 0; k < limit; k++) begin
			if (!table_used[k] && table_size[k] >= r.size_value) begin
				table_used[k] = 1'b1;
				o.granted = 1'b1;
				o.chosen_block = 5'(k);
				o.chosen_size = table_size[k];
				o.leftover = table_size[k] - r.size_value;
				return 1'b1;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [15:0] random_block_size();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 1023));
			2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(1024, 16383));
		endcase
	endfunction

	function automatic ffba_in_t random_request();
		ffba_in_t r;
		int lim;
		int k;
		logic [15:0] base;
		lim = (table_count > NUM_ENTRIES) ? NUM_ENTRIES : int'(table_count);
		k = (lim == 0) ? $urandom_range(0, NUM_ENTRIES - 1) : $urandom_range(0, lim - 1);
		base = table_size[k];
		r.block_slot = 5'($urandom);
		if ($urandom_range(0, 99) < 40) begin
			r.cmd = CMD_LOAD;
			if (lim > 0 && $urandom_range(0, 3) != 0)
				r.block_slot = 5'(k);
			r.size_value = random_block_size();
		end else begin
			r.cmd = CMD_ALLOC;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: r.size_value = (base > 3) ? base - 16'($urandom_range(0, 3)) : base;
				5: r.size_value = base + 16'd1;
				6, 7: r.size_value = 16'($urandom_range(0, 255));
				8: r.size_value = 16'($urandom);
				default: r.size_value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			endcase
		end
		return r;
	endfunction

	task automatic report_error(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (error_count < MAX_PRINTS)
			$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	task automatic send_item(input ffba_in_t r, input bit typed, input ffba_out_t want);
		ffba_out_t predicted;
		item <= r;
		item_valid <= 1'b1;
		offering = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		accepted_items++;
		if (first_fit_predict(r, predicted))
			grants_due.push_back(typed ? want : predicted);
	endtask

	task automatic pace(input bit no_gaps);
		int gap;
		burst_left--;
		if (burst_left > 0)
			return;
		burst_left = $urandom_range(1, 24);
		gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		if (gap > 0) begin
			item_valid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_block_count(input logic [5:0] value);
		if (offering) begin
			item_valid <= 1'b0;
			offering = 1'b0;
		end
		@(posedge clk);
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		table_count = value;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (grants_due.size() == 0) begin
				report_error("result with no request outstanding", result.chosen_size, '0);
			end else begin
				oldest = grants_due.pop_front();
				if (result.granted !== oldest.granted)
					report_error("granted", 16'(result.granted), 16'(oldest.granted));
				if (result.chosen_block !== oldest.chosen_block)
					report_error("chosen_block", 16'(result.chosen_block),
						16'(oldest.chosen_block));
				if (result.chosen_size !== oldest.chosen_size)
					report_error("chosen_size", result.chosen_size, oldest.chosen_size);
				if (result.leftover !== oldest.leftover)
					report_error("leftover", result.leftover, oldest.leftover);
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int cyc;
		int held_for;
		int mode;
		bit held;
		logic [7:0] pat;
		cyc = 0;
		mode = 0;
		held = 1'b0;
		pat = 8'b1011_0010;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 2);
			if (!held && accepted_items >= 600) begin
				held = 1'b1;
				result_stall <= 1'b1;
				held_for = 0;
				while (held_for < HOLD_CYCLES) begin
					@(posedge clk);
					held_for++;
				end
			end else begin
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 2) == 0);
					default: begin
						result_stall <= pat[0];
						pat = {pat[0], pat[7:1]};
					end
				endcase
			end
		end
	end

	initial begin
		ffba_in_t sweep;
		logic [5:0] count;
		for (int k = 0; k < NUM_ENTRIES; k++) begin
			table_size[k] = '0;
			table_used[k] = 1'b0;
		end
		table_count = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				write_block_count(directed_rows[i].count);
			end else begin
				send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
				pace(1'b0);
			end
		end

		for (int p = 0; p < 8; p++) begin
			count = (p == 5) ? 6'($urandom_range(3, 31)) : PHASE_COUNTS[p];
			write_block_count(count);
			if (p == 0) begin
				// every entry loaded before any search can reach it
				for (int s = 0; s < NUM_ENTRIES; s++) begin
					sweep.cmd = CMD_LOAD;
					sweep.block_slot = 5'(s);
					sweep.size_value = random_block_size();
					send_item(sweep, 1'b0, NO_FIT);
					pace(1'b0);
				end
			end
			repeat (PHASE_ITEMS) begin
				send_item(random_request(), 1'b0, NO_FIT);
				pace(p == 3);
			end
		end

		if (offering) begin
			item_valid <= 1'b0;
			offering = 1'b0;
		end
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && grants_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
